// ===== sv/joystick_servo_slew_command_macros.svh =====
// Assertion macros shared by the servo slew command block
`ifndef JOYSTICK_SERVO_SLEW_COMMAND_MACROS_SVH
`define JOYSTICK_SERVO_SLEW_COMMAND_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge, off while reset is low
`define JSSC_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("jssc assertion failed");
// Check a property on every rising edge, reset included
`define JSSC_ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("jssc assertion failed");
`else
`define JSSC_ASSERT(name, clk, rst_n, prop)
`define JSSC_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// ===== sv/jssc_pkg.sv =====
package jssc_pkg;

	// Field widths
	localparam int SAMPLE_W = 12;
	localparam int ANGLE_W  = 8;
	localparam int DUTY_W   = 11;

	// Divider sizing: numerator is distance times angle span, divisor is a sample span
	localparam int DIV_NUM_W = 20;
	localparam int DIV_DEN_W = 12;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd4095;
	localparam logic [ANGLE_W-1:0]  MID_ANGLE  = 8'd90;
	localparam logic [ANGLE_W-1:0]  ANGLE_TOP  = 8'd180;

	// Axis codes
	localparam logic AXIS_X = 1'b0;
	localparam logic AXIS_Y = 1'b1;

	// Register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_CENTER_X  = 3'd0,
		REG_CENTER_Y  = 3'd1,
		REG_DEAD_BAND = 3'd2,
		REG_ANGLE_MIN = 3'd3,
		REG_ANGLE_MAX = 3'd4,
		REG_MAX_STEP  = 3'd5,
		REG_TRIM_X    = 3'd6,
		REG_TRIM_Y    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [11:0]       center_x;
		logic [11:0]       center_y;
		logic [10:0]       dead_band;
		logic [6:0]        angle_min;
		logic [7:0]        angle_max;
		logic [6:0]        max_step;
		logic signed [7:0] trim_x;
		logic signed [7:0] trim_y;
	} cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MAP,
		S_DIV,
		S_TGT,
		S_SLEW,
		S_DUTY,
		S_OUT
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_in;
		logic div_start;
		logic tgt_ld;
		logic slew_ld;
		logic duty_ld;
		logic out_ld;
		logic axis;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic div_done;
	} sts_t;

	// Angle to duty table, 0..180 degrees, built at elaboration
	localparam int DUTY_PULSE_MIN  = 500;
	localparam int DUTY_PULSE_SPAN = 2000;
	localparam int DUTY_ANGLES     = 180;
	localparam int DUTY_FULL       = 16383;
	localparam int DUTY_PERIOD     = 20000;

	typedef logic [DUTY_W-1:0] duty_lut_t [0:DUTY_ANGLES];

	function automatic duty_lut_t build_duty_lut();
		duty_lut_t lut;
		int pulse;
		for (int i = 0; i <= DUTY_ANGLES; i++) begin
			pulse = DUTY_PULSE_MIN + (i * DUTY_PULSE_SPAN) / DUTY_ANGLES;
			lut[i] = DUTY_W'((pulse * DUTY_FULL) / DUTY_PERIOD);
		end
		return lut;
	endfunction

	localparam duty_lut_t DUTY_LUT = build_duty_lut();

endpackage

// ===== sv/joystick_servo_slew_command.sv =====
// m_tvalid rises once both axes are done and the output register is loaded.
// A new sample pair is taken only while idle, after the last pair is through; each axis
// goes through map, divide, target, slew and duty, using the shared one-bit-per-cycle divider.
// A finished result waits in the output register; the next input is taken meanwhile.
// Reset (arst_n low, asynchronous) restores register defaults and both angles to 90.
module joystick_servo_slew_command (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // sample_x [11:0], sample_y [23:12]
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // angle_x [7:0], angle_y [15:8], duty_x [26:16],
	                               // duty_y [37:27], zero [39:38]
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	jssc_pkg::cfg_t   cfg_q;
	jssc_pkg::cmd_t   cmd;
	jssc_pkg::sts_t   sts;
	jssc_pkg::reg_idx_t reg_idx;
	logic             cfg_wr;
	logic [jssc_pkg::ANGLE_W-1:0] angle_x;
	logic [jssc_pkg::ANGLE_W-1:0] angle_y;
	logic [jssc_pkg::DUTY_W-1:0]  duty_x;
	logic [jssc_pkg::DUTY_W-1:0]  duty_y;

	assign pready  = 1'b1;
	assign reg_idx = jssc_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Register file writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x  <= 12'd2048;
			cfg_q.center_y  <= 12'd2048;
			cfg_q.dead_band <= 11'd120;
			cfg_q.angle_min <= 7'd65;
			cfg_q.angle_max <= 8'd115;
			cfg_q.max_step  <= 7'd3;
			cfg_q.trim_x    <= 8'sd0;
			cfg_q.trim_y    <= -8'sd9;
		end else if (cfg_wr) begin
			case (reg_idx)
				jssc_pkg::REG_CENTER_X:  cfg_q.center_x  <= pwdata[11:0];
				jssc_pkg::REG_CENTER_Y:  cfg_q.center_y  <= pwdata[11:0];
				jssc_pkg::REG_DEAD_BAND: cfg_q.dead_band <= pwdata[10:0];
				jssc_pkg::REG_ANGLE_MIN: cfg_q.angle_min <= pwdata[6:0];
				jssc_pkg::REG_ANGLE_MAX: cfg_q.angle_max <= pwdata[7:0];
				jssc_pkg::REG_MAX_STEP:  cfg_q.max_step  <= pwdata[6:0];
				jssc_pkg::REG_TRIM_X:    cfg_q.trim_x    <= $signed(pwdata[7:0]);
				jssc_pkg::REG_TRIM_Y:    cfg_q.trim_y    <= $signed(pwdata[7:0]);
				default: begin
				end
			endcase
		end
	end

	// Register file reads
	always_comb begin
		case (reg_idx)
			jssc_pkg::REG_CENTER_X:  prdata = {20'd0, cfg_q.center_x};
			jssc_pkg::REG_CENTER_Y:  prdata = {20'd0, cfg_q.center_y};
			jssc_pkg::REG_DEAD_BAND: prdata = {21'd0, cfg_q.dead_band};
			jssc_pkg::REG_ANGLE_MIN: prdata = {25'd0, cfg_q.angle_min};
			jssc_pkg::REG_ANGLE_MAX: prdata = {24'd0, cfg_q.angle_max};
			jssc_pkg::REG_MAX_STEP:  prdata = {25'd0, cfg_q.max_step};
			jssc_pkg::REG_TRIM_X:    prdata = {24'd0, cfg_q.trim_x};
			jssc_pkg::REG_TRIM_Y:    prdata = {24'd0, cfg_q.trim_y};
			default:                 prdata = '0;
		endcase
	end

	jssc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	jssc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.sts      (sts),
		.sample_x (s_tdata[11:0]),
		.sample_y (s_tdata[23:12]),
		.angle_x  (angle_x),
		.angle_y  (angle_y),
		.duty_x   (duty_x),
		.duty_y   (duty_y)
	);

	assign m_tdata = {2'b00, duty_y, duty_x, angle_y, angle_x};

endmodule

// ===== sv/jssc_div.sv =====
module jssc_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [jssc_pkg::DIV_NUM_W-1:0] dividend,
	input  logic [jssc_pkg::DIV_DEN_W-1:0] divisor,
	output logic [jssc_pkg::DIV_NUM_W-1:0] quotient,
	output logic                           done
);

	localparam int NW = jssc_pkg::DIV_NUM_W;
	localparam int DW = jssc_pkg::DIV_DEN_W;
	localparam int CW = jssc_pkg::DIV_CNT_W;
	localparam logic [CW-1:0] LAST_STEP = CW'(NW - 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;

	logic [DW:0]   trial;
	logic          fits;
	logic [DW:0]   diff;

	// One restoring step: bring down the next dividend bit and try a subtract
	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	// Sequence control of the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q + 1'b1;
			done_q <= cnt_q == LAST_STEP;
			busy_q <= cnt_q != LAST_STEP;
		end else begin
			done_q <= 1'b0;
		end
	end

	// Shift remainder and quotient one bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== sv/jssc_dp.sv =====
module jssc_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  jssc_pkg::cfg_t                  cfg,
	input  jssc_pkg::cmd_t                  cmd,
	output jssc_pkg::sts_t                  sts,
	input  logic [jssc_pkg::SAMPLE_W-1:0]   sample_x,
	input  logic [jssc_pkg::SAMPLE_W-1:0]   sample_y,
	output logic [jssc_pkg::ANGLE_W-1:0]    angle_x,
	output logic [jssc_pkg::ANGLE_W-1:0]    angle_y,
	output logic [jssc_pkg::DUTY_W-1:0]     duty_x,
	output logic [jssc_pkg::DUTY_W-1:0]     duty_y
);

	localparam int SW = jssc_pkg::SAMPLE_W;
	localparam int AW = jssc_pkg::ANGLE_W;
	localparam int NW = jssc_pkg::DIV_NUM_W;
	localparam int DW = jssc_pkg::DIV_DEN_W;

	logic [SW-1:0] sample_q [2];
	logic [AW-1:0] cur_q    [2];
	logic [jssc_pkg::DUTY_W-1:0] duty_q [2];
	logic          neg_q;
	logic          band_q;
	logic [AW-1:0] tgt_q;
	logic [AW-1:0] angle_x_q;
	logic [AW-1:0] angle_y_q;
	logic [jssc_pkg::DUTY_W-1:0] duty_x_q;
	logic [jssc_pkg::DUTY_W-1:0] duty_y_q;

	logic [SW-1:0]        smp;
	logic [SW-1:0]        ctr;
	logic [SW-1:0]        smp_c;
	logic signed [13:0]   lo;
	logic [13:0]          hi;
	logic [13:0]          s14;
	logic                 below;
	logic                 above;
	logic signed [8:0]    k;
	logic                 k_neg;
	logic [7:0]           k_mag;
	logic [13:0]          dist14;
	logic [DW-1:0]        dist12;
	logic [DW-1:0]        span;
	logic [NW-1:0]        prod;
	logic [NW-1:0]        quo;
	logic signed [10:0]   tgt_a;
	logic signed [10:0]   mn11;
	logic signed [10:0]   mx11;
	logic [AW-1:0]        cur;
	logic signed [9:0]    dlt;
	logic signed [9:0]    stp;
	logic [AW-1:0]        cur_new;
	logic signed [9:0]    trim_a;
	logic [AW-1:0]        duty_idx;

	// Capture the samples of an accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sample_q[jssc_pkg::AXIS_X] <= sample_x;
			sample_q[jssc_pkg::AXIS_Y] <= sample_y;
		end
	end

	// Map: classify against the dead band and form numerator and span
	always_comb begin
		smp    = sample_q[cmd.axis];
		ctr    = (cmd.axis == jssc_pkg::AXIS_Y) ? cfg.center_y : cfg.center_x;
		smp_c  = (smp > jssc_pkg::SAMPLE_MAX) ? jssc_pkg::SAMPLE_MAX : smp;
		lo     = $signed({2'b00, ctr}) - $signed({3'b000, cfg.dead_band});
		hi     = {2'b00, ctr} + {3'b000, cfg.dead_band};
		s14    = {2'b00, smp_c};
		below  = $signed(s14) < lo;
		above  = s14 > hi;
		k      = '0;
		dist14 = '0;
		span   = DW'(1);
		if (below) begin
			k      = $signed(9'd90) - $signed({2'b00, cfg.angle_min});
			dist14 = 14'(lo - $signed(s14));
			span   = lo[DW-1:0];
		end else if (above) begin
			k      = $signed({1'b0, cfg.angle_max}) - $signed(9'd90);
			dist14 = s14 - hi;
			span   = DW'({2'b00, jssc_pkg::SAMPLE_MAX} - hi);
		end
		dist12 = dist14[DW-1:0];
		k_neg  = k[8];
		k_mag  = k_neg ? 8'(-k) : 8'(k);
		prod   = NW'(dist12) * NW'(k_mag);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q  <= below ^ k_neg;
			band_q <= !below && !above;
		end
	end

	jssc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod),
		.divisor  (span),
		.quotient (quo),
		.done     (sts.div_done)
	);

	// Target: offset from mid angle, then raise to min and lower to max;
	// a sample inside the dead band stays at mid angle unclamped
	always_comb begin
		mn11  = $signed({4'b0000, cfg.angle_min});
		mx11  = $signed({3'b000, cfg.angle_max});
		tgt_a = neg_q ? $signed(11'd90) - $signed({2'b00, quo[8:0]})
		              : $signed(11'd90) + $signed({2'b00, quo[8:0]});
		if (!band_q && tgt_a < mn11) begin
			tgt_a = mn11;
		end
		if (!band_q && tgt_a > mx11) begin
			tgt_a = mx11;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tgt_ld) begin
			tgt_q <= tgt_a[AW-1:0];
		end
	end

	// Slew: move the kept angle toward the target by at most max_step
	always_comb begin
		cur = cur_q[cmd.axis];
		stp = $signed({3'b000, cfg.max_step});
		dlt = $signed({2'b00, tgt_q}) - $signed({2'b00, cur});
		if (dlt > stp) begin
			dlt = stp;
		end
		if (dlt < -stp) begin
			dlt = -stp;
		end
		cur_new = AW'($signed({2'b00, cur}) + dlt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				cur_q[i] <= jssc_pkg::MID_ANGLE;
			end
		end else if (cmd.slew_ld) begin
			cur_q[cmd.axis] <= cur_new;
		end
	end

	// Duty: add trim, clamp to 0..180, look up the duty
	always_comb begin
		trim_a = $signed({2'b00, cur}) +
			((cmd.axis == jssc_pkg::AXIS_Y) ? 10'(cfg.trim_y) : 10'(cfg.trim_x));
		if (trim_a < 0) begin
			duty_idx = '0;
		end else if (trim_a > $signed({2'b00, jssc_pkg::ANGLE_TOP})) begin
			duty_idx = jssc_pkg::ANGLE_TOP;
		end else begin
			duty_idx = trim_a[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.duty_ld) begin
			duty_q[cmd.axis] <= jssc_pkg::DUTY_LUT[duty_idx];
		end
	end

	// Output register, loaded once both axes are done
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			angle_x_q <= cur_q[jssc_pkg::AXIS_X];
			angle_y_q <= cur_q[jssc_pkg::AXIS_Y];
			duty_x_q  <= duty_q[jssc_pkg::AXIS_X];
			duty_y_q  <= duty_q[jssc_pkg::AXIS_Y];
		end
	end

	assign angle_x = angle_x_q;
	assign angle_y = angle_y_q;
	assign duty_x  = duty_x_q;
	assign duty_y  = duty_y_q;

endmodule

// ===== sv/jssc_ctrl.sv =====
`include "joystick_servo_slew_command_macros.svh"

module jssc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  jssc_pkg::sts_t sts,
	output jssc_pkg::cmd_t cmd
);

	jssc_pkg::state_t state_q;
	jssc_pkg::state_t state_d;
	logic             axis_q;
	logic             axis_d;
	logic             out_valid_q;

	// State and axis registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jssc_pkg::S_IDLE;
			axis_q  <= jssc_pkg::AXIS_X;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		axis_d   = axis_q;
		cmd      = '0;
		cmd.axis = axis_q;
		case (state_q)
			jssc_pkg::S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					axis_d      = jssc_pkg::AXIS_X;
					state_d     = jssc_pkg::S_MAP;
				end
			end
			jssc_pkg::S_MAP: begin
				cmd.div_start = 1'b1;
				state_d       = jssc_pkg::S_DIV;
			end
			jssc_pkg::S_DIV: begin
				if (sts.div_done) begin
					state_d = jssc_pkg::S_TGT;
				end
			end
			jssc_pkg::S_TGT: begin
				cmd.tgt_ld = 1'b1;
				state_d    = jssc_pkg::S_SLEW;
			end
			jssc_pkg::S_SLEW: begin
				cmd.slew_ld = 1'b1;
				state_d     = jssc_pkg::S_DUTY;
			end
			jssc_pkg::S_DUTY: begin
				cmd.duty_ld = 1'b1;
				if (axis_q == jssc_pkg::AXIS_Y) begin
					state_d = jssc_pkg::S_OUT;
				end else begin
					axis_d  = jssc_pkg::AXIS_Y;
					state_d = jssc_pkg::S_MAP;
				end
			end
			jssc_pkg::S_OUT: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_ld = 1'b1;
					state_d    = jssc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = jssc_pkg::S_IDLE;
			end
		endcase
	end

	// Output valid: set on load, drop once the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign s_tready = state_q == jssc_pkg::S_IDLE;
	assign m_tvalid = out_valid_q;

	`JSSC_ASSERT(a_accept_starts_x, clk, arst_n, (s_tvalid && s_tready) |=> (state_q == jssc_pkg::S_MAP && axis_q == jssc_pkg::AXIS_X))
	`JSSC_ASSERT(a_div_done_moves, clk, arst_n, (state_q == jssc_pkg::S_DIV && sts.div_done) |=> (state_q == jssc_pkg::S_TGT))
	`JSSC_ASSERT(a_x_then_y, clk, arst_n, (state_q == jssc_pkg::S_DUTY && axis_q == jssc_pkg::AXIS_X) |=> (state_q == jssc_pkg::S_MAP && axis_q == jssc_pkg::AXIS_Y))
	`JSSC_ASSERT(a_load_shows_valid, clk, arst_n, cmd.out_ld |=> m_tvalid)

endmodule
